FILE: hw/rtl/sfr_pkg.sv
// Shared types, constants and the CRC-8 step function for the status frame receiver.
// Depends on nothing; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    // Longest frame the byte counter can track, including the CRC byte.
    localparam int MAX_FRAME = 32;
    // Shortest frame: header, three payload bytes and the CRC byte.
    localparam int MIN_FRAME = 5;
    localparam int CNT_W     = $clog2(MAX_FRAME);

    // Queue depth between front and back; must be a power of two.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [7:0] CRC_POLY    = 8'h8C;

    // Input operation codes.
    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK_10MS = 2'd1;
    localparam logic [1:0] OP_TICK_1S = 2'd2;

    // Request kinds as the back part sees them.
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_TICK10 = 2'd1;
    localparam logic [1:0] KIND_TICK1S = 2'd2;

    // Result event codes.
    localparam logic [1:0] EV_GOOD_FRAME   = 2'd0;
    localparam logic [1:0] EV_LINK_TIMEOUT = 2'd1;
    localparam logic [1:0] EV_REPLY_DUE    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_LENGTH = 2'd0;
    localparam logic [1:0] CFG_LINK_RELOAD  = 2'd1;
    localparam logic [1:0] CFG_REPLY_RELOAD = 2'd2;

    // Reset values of the configuration registers and the link timer.
    localparam logic [5:0] RST_FRAME_LENGTH = 6'd5;
    localparam logic [7:0] RST_LINK_RELOAD  = 8'd160;
    localparam logic [7:0] RST_REPLY_RELOAD = 8'd2;

    // Positions of the payload bytes inside a frame.
    localparam logic [CNT_W-1:0] POS_HEADER = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_CTRL   = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_AUX    = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_FAN    = CNT_W'(3);

    // One classified request travelling from front to back.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       start;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic [1:0] event_res;
        logic       power_on;
        logic       compressor_on;
        logic       sleep_on;
        logic       self_test_on;
        logic [1:0] swing_pattern;
        logic       swing_on;
        logic       uvc_on;
        logic [7:0] fan_pwm;
        logic       fan_supply_on;
    } t_result;

    // Reflected CRC-8 update over one byte, eight shift steps.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/status_frame_receiver_core.sv
// A result becomes valid once its request has passed two registers: the request enters the
// queue at acceptance; the back part pops it and loads the result register when that register
// is free or being emptied. Throughput: one request per cycle with an eight-step CRC update,
// unless the result register stalls; the queue and result register let either side stall.
// Reset: synchronous, active low; clears queue, receiver state and reply timer, and loads
// link timer 160 and config defaults (frame length 5, link reload 160, reply reload 2).
// Top level; depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
`timescale 1ns / 1ps
`default_nettype none

module status_frame_receiver_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_wdata,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] rx_byte, [8] frame_start, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [0] power_on, [1] compressor_on, [2] sleep_on,
                                        // [3] self_test_on, [5:4] swing_pattern,
                                        // [6] swing_on, [7] uvc_on, [15:8] fan_pwm,
                                        // [16] fan_supply_on, rest zero
    output logic [1:0]       m_tuser    // [1:0] event_res
);

    logic             w_q_ready;
    logic             w_q_push;
    sfr_pkg::t_cmd    w_push_cmd;
    logic             w_q_valid;
    logic             w_q_pop;
    sfr_pkg::t_cmd    w_pop_cmd;
    sfr_pkg::t_result w_res;

    sfr_front u_front (
        .i_s_tvalid (s_tvalid),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_s_tready (s_tready),
        .i_q_ready  (w_q_ready),
        .o_q_push   (w_q_push),
        .o_q_cmd    (w_push_cmd)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_push_cmd),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_pop_cmd)
    );

    sfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_pop_cmd),
        .o_q_pop     (w_q_pop),
        .o_res_valid (m_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_tready)
    );

    // The event kind travels on tuser; the status fields fill tdata from the lowest bit.
    assign m_tuser = w_res.event_res;
    assign m_tdata = {7'd0, w_res.fan_supply_on, w_res.fan_pwm, w_res.uvc_on, w_res.swing_on,
                      w_res.swing_pattern, w_res.self_test_on, w_res.sleep_on,
                      w_res.compressor_on, w_res.power_on};

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_front.sv
// Front part: accepts input requests and classifies them into queue entries.
// Depends on sfr_pkg; feeds sfr_queue.
`timescale 1ns / 1ps
`default_nettype none

module sfr_front (
    input  wire logic          i_s_tvalid,
    input  wire logic [15:0]   i_s_tdata,
    input  wire logic [1:0]    i_s_tuser,
    output logic               o_s_tready,
    input  wire logic          i_q_ready,
    output logic               o_q_push,
    output sfr_pkg::t_cmd      o_q_cmd
);

    logic w_known;

    // The front takes a request whenever the queue has room.
    assign o_s_tready = i_q_ready;

    // Unused operation codes are taken and dropped here.
    always_comb begin
        w_known       = 1'b1;
        o_q_cmd.kind  = sfr_pkg::KIND_BYTE;
        o_q_cmd.data  = i_s_tdata[7:0];
        o_q_cmd.start = i_s_tdata[8];
        case (i_s_tuser)
            sfr_pkg::OP_RX_BYTE:   o_q_cmd.kind = sfr_pkg::KIND_BYTE;
            sfr_pkg::OP_TICK_10MS: o_q_cmd.kind = sfr_pkg::KIND_TICK10;
            sfr_pkg::OP_TICK_1S:   o_q_cmd.kind = sfr_pkg::KIND_TICK1S;
            default:               w_known = 1'b0;
        endcase
    end

    assign o_q_push = i_s_tvalid && i_q_ready && w_known;

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_queue.sv
// Short request queue between front and back so that each side stalls on its own.
// Depends on sfr_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module sfr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sfr_pkg::t_cmd i_cmd,
    output logic               o_ready,
    input  wire logic          i_pop,
    output logic               o_valid,
    output sfr_pkg::t_cmd      o_cmd
);

    sfr_pkg::t_cmd                  r_mem [sfr_pkg::QDEPTH];
    logic [sfr_pkg::QPTR_W-1:0]     r_wptr, n_wptr;
    logic [sfr_pkg::QPTR_W-1:0]     r_rptr, n_rptr;
    logic [sfr_pkg::QCNT_W-1:0]     r_count, n_count;
    logic                           w_do_pop;

    // No request is taken while reset is held.
    assign o_ready  = i_rst_n && (r_count != sfr_pkg::QCNT_W'(sfr_pkg::QDEPTH));
    assign o_valid  = r_count != '0;
    assign o_cmd    = r_mem[r_rptr];
    assign w_do_pop = i_pop && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sfr_pkg::QCNT_W'(sfr_pkg::QDEPTH))
        else $error("queue fill count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("request pushed into a full queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wptr == r_rptr))
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_back.sv
// Back part: frame reception, CRC check, timers, configuration and the result register.
// Depends on sfr_pkg; pops requests from sfr_queue.
`timescale 1ns / 1ps
`default_nettype none

module sfr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [7:0]    i_cfg_wdata,
    input  wire logic          i_q_valid,
    input  wire sfr_pkg::t_cmd i_q_cmd,
    output logic               o_q_pop,
    output logic               o_res_valid,
    output sfr_pkg::t_result   o_res,
    input  wire logic          i_res_ready
);

    localparam int CNT_W = sfr_pkg::CNT_W;

    // Configuration registers.
    logic [5:0]       r_cfg_len;
    logic [7:0]       r_cfg_link;
    logic [7:0]       r_cfg_reply;

    // Receiver and timer state.
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_receiving, n_receiving;
    logic [7:0]       r_crc, n_crc;
    logic             r_header_good, n_header_good;
    logic [7:0]       r_ctrl, n_ctrl;
    logic [7:0]       r_aux, n_aux;
    logic [7:0]       r_fan, n_fan;
    logic [7:0]       r_link, n_link;
    logic [7:0]       r_reply, n_reply;
    logic             r_power, n_power;

    // Result register.
    logic             r_out_valid;
    sfr_pkg::t_result r_out;
    logic             w_res_fire;
    sfr_pkg::t_result w_res;

    logic [CNT_W-1:0] w_last;
    logic [CNT_W-1:0] w_idx;
    logic             w_adv;

    // The back moves on when the result register is free or being emptied.
    assign w_adv       = !r_out_valid || i_res_ready;
    assign o_q_pop     = i_q_valid && w_adv;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Index of the CRC byte, with the frame length clamped to the supported range.
    always_comb begin
        if (r_cfg_len < 6'(sfr_pkg::MIN_FRAME)) begin
            w_last = CNT_W'(sfr_pkg::MIN_FRAME - 1);
        end else if (8'(r_cfg_len) > 8'(sfr_pkg::MAX_FRAME)) begin
            w_last = CNT_W'(sfr_pkg::MAX_FRAME - 1);
        end else begin
            w_last = CNT_W'(r_cfg_len - 6'd1);
        end
    end

    // Execute one request per cycle while the result register is free or being emptied.
    always_comb begin
        n_cnt         = r_cnt;
        n_receiving   = r_receiving;
        n_crc         = r_crc;
        n_header_good = r_header_good;
        n_ctrl        = r_ctrl;
        n_aux         = r_aux;
        n_fan         = r_fan;
        n_link        = r_link;
        n_reply       = r_reply;
        n_power       = r_power;
        w_res_fire    = 1'b0;
        w_res         = '0;
        w_idx         = i_q_cmd.start ? sfr_pkg::POS_HEADER : r_cnt;
        if (o_q_pop) begin
            case (i_q_cmd.kind)
                sfr_pkg::KIND_BYTE: begin
                    if (i_q_cmd.start || r_receiving) begin
                        // A count at or past the end (frame shortened mid-frame) is the CRC byte.
                        if (w_idx >= w_last) begin
                            // CRC byte closes the frame either way.
                            n_receiving = 1'b0;
                            n_cnt       = '0;
                            if (r_header_good && (i_q_cmd.data == r_crc)) begin
                                n_power             = r_ctrl[0];
                                n_link              = r_cfg_link;
                                n_reply             = r_cfg_reply;
                                w_res_fire          = 1'b1;
                                w_res.event_res     = sfr_pkg::EV_GOOD_FRAME;
                                w_res.power_on      = r_ctrl[0];
                                w_res.compressor_on = r_ctrl[1];
                                w_res.sleep_on      = r_ctrl[2];
                                w_res.self_test_on  = r_ctrl[3];
                                w_res.swing_pattern = r_ctrl[5:4];
                                w_res.swing_on      = r_ctrl[6];
                                w_res.uvc_on        = r_ctrl[7];
                                w_res.fan_pwm       = r_fan;
                                w_res.fan_supply_on = r_aux[7];
                            end
                        end else begin
                            n_receiving = 1'b1;
                            n_cnt       = w_idx + 1'b1;
                            if (w_idx == sfr_pkg::POS_HEADER) begin
                                n_header_good = i_q_cmd.data == sfr_pkg::HEADER_BYTE;
                                n_crc         = sfr_pkg::crc8_update(8'd0, i_q_cmd.data);
                            end else begin
                                n_crc = sfr_pkg::crc8_update(r_crc, i_q_cmd.data);
                                if (w_idx == sfr_pkg::POS_CTRL) begin
                                    n_ctrl = i_q_cmd.data;
                                end else if (w_idx == sfr_pkg::POS_AUX) begin
                                    n_aux = i_q_cmd.data;
                                end else if (w_idx == sfr_pkg::POS_FAN) begin
                                    n_fan = i_q_cmd.data;
                                end
                            end
                        end
                    end
                end
                sfr_pkg::KIND_TICK10: begin
                    if (r_reply != 8'd0) begin
                        n_reply = r_reply - 8'd1;
                        if (r_reply == 8'd1) begin
                            w_res_fire      = 1'b1;
                            w_res.event_res = sfr_pkg::EV_REPLY_DUE;
                            w_res.power_on  = r_power;
                        end
                    end
                end
                sfr_pkg::KIND_TICK1S: begin
                    if (r_link != 8'd0) begin
                        n_link = r_link - 8'd1;
                        if (r_link == 8'd1) begin
                            n_power         = 1'b0;
                            w_res_fire      = 1'b1;
                            w_res.event_res = sfr_pkg::EV_LINK_TIMEOUT;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= '0;
            r_receiving   <= 1'b0;
            r_crc         <= '0;
            r_header_good <= 1'b0;
            r_ctrl        <= '0;
            r_aux         <= '0;
            r_fan         <= '0;
            r_link        <= sfr_pkg::RST_LINK_RELOAD;
            r_reply       <= '0;
            r_power       <= 1'b0;
        end else begin
            r_cnt         <= n_cnt;
            r_receiving   <= n_receiving;
            r_crc         <= n_crc;
            r_header_good <= n_header_good;
            r_ctrl        <= n_ctrl;
            r_aux         <= n_aux;
            r_fan         <= n_fan;
            r_link        <= n_link;
            r_reply       <= n_reply;
            r_power       <= n_power;
        end
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len   <= sfr_pkg::RST_FRAME_LENGTH;
            r_cfg_link  <= sfr_pkg::RST_LINK_RELOAD;
            r_cfg_reply <= sfr_pkg::RST_REPLY_RELOAD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfr_pkg::CFG_FRAME_LENGTH: r_cfg_len   <= i_cfg_wdata[5:0];
                sfr_pkg::CFG_LINK_RELOAD:  r_cfg_link  <= i_cfg_wdata;
                sfr_pkg::CFG_REPLY_RELOAD: r_cfg_reply <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res_fire;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_res_fire) begin
            r_out <= w_res;
        end
    end

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_receiving |-> (r_cnt == '0))
        else $error("byte count not cleared with no frame open");

    a_timeout_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_fire && w_res.event_res == sfr_pkg::EV_LINK_TIMEOUT) |=> (r_power == 1'b0))
        else $error("power still on after a link timeout");

    a_good_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_fire && w_res.event_res == sfr_pkg::EV_GOOD_FRAME)
        |=> (r_link == $past(r_cfg_link) && r_reply == $past(r_cfg_reply)))
        else $error("timers not reloaded after a good frame");

endmodule

`default_nettype wire
